// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: assertion shorthands for the barycentric weight checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TBW_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tbw assertion failed");

// next-cycle implication, disabled in reset
`define TBW_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tbw assertion failed");

`endif

// ===== hw/rtl/tbw_pkg.sv =====
// tbw_pkg: shared constants, state enum and queue status type.
// No dependencies; imported by all tbw modules.
`default_nettype none

package tbw_pkg;

  localparam int NUM_CORNERS = 4;
  localparam int COORDS      = 3;
  localparam int NUM_ROWS    = NUM_CORNERS + 1;   // four corners plus the point
  localparam int WEIGHT_W    = 32;

  localparam logic [WEIGHT_W-1:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0] W_MIN = 32'h8000_0000;

  localparam logic [2:0] LAST_STEP = 3'd5;        // six products per phase
  localparam logic [2:0] LAST_DET  = 3'd4;        // det 0 = denominator
  localparam logic [4:0] LAST_BIT  = 5'd31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DETEND,
    S_DIV,
    S_WEIGHT,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tbw_front.sv =====
// tbw_front: accepts words, keeps the corner store, pushes queries with a snapshot.
// Depends on tbw_pkg.
`default_nettype none

module tbw_front import tbw_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  localparam int ENTRY_W = NUM_ROWS * COORDS * COORD_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [COORD_WIDTH-1:0] coord_x,
  input  wire logic [COORD_WIDTH-1:0] coord_y,
  input  wire logic [COORD_WIDTH-1:0] coord_z,
  input  wire logic [1:0]             vertex_slot,
  input  wire logic                   is_query,
  input  wire q_status_t              q_status,
  output logic                        busy,
  output logic                        push,
  output logic [ENTRY_W-1:0]          push_data
);

  logic [COORD_WIDTH-1:0] store [NUM_CORNERS][COORDS];
  logic                   accept;

  assign busy   = q_status.full;
  assign accept = start && !busy;
  assign push   = accept && is_query;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_CORNERS; r++) begin
        for (int k = 0; k < COORDS; k++) begin
          store[r][k] <= '0;
        end
      end
    end else if (accept && !is_query) begin
      store[vertex_slot][0] <= coord_x;
      store[vertex_slot][1] <= coord_y;
      store[vertex_slot][2] <= coord_z;
    end
  end

  // entry layout: corners 0..3 then the point, x/y/z each
  always_comb begin
    for (int r = 0; r < NUM_CORNERS; r++) begin
      for (int k = 0; k < COORDS; k++) begin
        push_data[(r*COORDS+k)*COORD_WIDTH +: COORD_WIDTH] = store[r][k];
      end
    end
    push_data[(NUM_CORNERS*COORDS+0)*COORD_WIDTH +: COORD_WIDTH] = coord_x;
    push_data[(NUM_CORNERS*COORDS+1)*COORD_WIDTH +: COORD_WIDTH] = coord_y;
    push_data[(NUM_CORNERS*COORDS+2)*COORD_WIDTH +: COORD_WIDTH] = coord_z;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbw_queue.sv =====
// tbw_queue: two-entry queue of query snapshots between front and back.
// Depends on tbw_pkg.
`default_nettype none

module tbw_queue import tbw_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output q_status_t             status,
  output logic [WIDTH-1:0]      head
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbw_back.sv =====
// tbw_back: determinant engine on one shared multiplier plus bit-serial divider.
// Depends on tbw_pkg.
`default_nettype none

module tbw_back import tbw_pkg::*; #(
  parameter int COORD_WIDTH      = 24,
  parameter int WEIGHT_FRAC_BITS = 24,
  localparam int ENTRY_W = NUM_ROWS * COORDS * COORD_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire q_status_t          q_status,
  input  wire logic [ENTRY_W-1:0] head,
  output logic                    pop,
  output logic                    done,
  output logic [WEIGHT_W-1:0]     weight_0,
  output logic [WEIGHT_W-1:0]     weight_1,
  output logic [WEIGHT_W-1:0]     weight_2,
  output logic [WEIGHT_W-1:0]     weight_3,
  output logic                    degenerate,
  output logic                    saturated
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;          // edge vector component
  localparam int BW   = DW + 2;          // second multiplier operand
  localparam int XW   = 2 * DW + 1;      // cross product component
  localparam int PW   = DW + BW;         // product
  localparam int DETW = 3 * DW + 3;      // determinant
  localparam int EW   = DETW + WEIGHT_W; // scaled numerator window

  back_state_t state, state_next;

  logic [ENTRY_W-1:0]      work;
  logic [2:0]              di;
  logic [2:0]              step;
  logic                    phase;        // 0: cross products, 1: dot product
  logic signed [PW-1:0]    preg;
  logic signed [XW-1:0]    cx, cy, cz;
  logic signed [DETW-1:0]  acc;
  logic [DETW-1:0]         dmag;
  logic                    dneg;
  logic [DETW-1:0]         rem;
  logic [WEIGHT_W-1:0]     low, quo;
  logic [4:0]              cnt;
  logic                    qneg, ovf;
  logic [WEIGHT_W-1:0]     w [NUM_CORNERS];
  logic                    deg, sat;

  logic signed [DW-1:0]    row [NUM_CORNERS][COORDS];
  logic signed [DW-1:0]    da [COORDS];
  logic signed [DW-1:0]    db [COORDS];
  logic signed [DW-1:0]    dc [COORDS];
  logic signed [DW-1:0]    opa, asel;
  logic signed [BW-1:0]    opb;
  logic signed [XW-1:0]    xsel;
  logic [DETW-1:0]         mag;
  logic [EW-1:0]           nx;
  logic [DETW-1:0]         nhi;
  logic                    over;
  logic [DETW:0]           trial;
  logic                    ge;
  logic                    wsat;
  logic [WEIGHT_W-1:0]     wval;
  logic [1:0]              widx;

  // rows of the current matrix: det di replaces corner di-1 by the point
  always_comb begin
    logic [CW-1:0] cv;
    cv = '0;
    for (int r = 0; r < NUM_CORNERS; r++) begin
      for (int k = 0; k < COORDS; k++) begin
        if (di == 3'(r + 1)) cv = work[(NUM_CORNERS*COORDS+k)*CW +: CW];
        else                 cv = work[(r*COORDS+k)*CW +: CW];
        row[r][k] = {cv[CW-1], cv};
      end
    end
    for (int k = 0; k < COORDS; k++) begin
      da[k] = row[1][k] - row[0][k];
      db[k] = row[2][k] - row[0][k];
      dc[k] = row[3][k] - row[0][k];
    end
  end

  // operand select; dot step splits each cross component into lo/hi halves
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (step[2:1])
      2'd0:    begin xsel = cx; asel = da[0]; end
      2'd1:    begin xsel = cy; asel = da[1]; end
      default: begin xsel = cz; asel = da[2]; end
    endcase
    if (!phase) begin
      unique case (step)
        3'd0:    begin opa = db[1]; opb = {{2{dc[2][DW-1]}}, dc[2]}; end
        3'd1:    begin opa = db[2]; opb = {{2{dc[1][DW-1]}}, dc[1]}; end
        3'd2:    begin opa = db[2]; opb = {{2{dc[0][DW-1]}}, dc[0]}; end
        3'd3:    begin opa = db[0]; opb = {{2{dc[2][DW-1]}}, dc[2]}; end
        3'd4:    begin opa = db[0]; opb = {{2{dc[1][DW-1]}}, dc[1]}; end
        3'd5:    begin opa = db[1]; opb = {{2{dc[0][DW-1]}}, dc[0]}; end
        default: begin opa = '0;    opb = '0; end
      endcase
    end else begin
      opa = asel;
      opb = step[0] ? {{2{xsel[XW-1]}}, xsel[XW-1:DW+1]} : {1'b0, xsel[DW:0]};
    end
  end

  // magnitude, scaled numerator, overflow test and divider trial compare
  assign mag   = acc[DETW-1] ? DETW'(-acc) : DETW'(acc);
  assign nx    = EW'(mag) << WEIGHT_FRAC_BITS;
  assign nhi   = nx[EW-1:WEIGHT_W];
  assign over  = (nhi >= dmag);
  assign trial = {rem, low[WEIGHT_W-1]};
  assign ge    = (trial >= {1'b0, dmag});

  assign wsat = ovf || (qneg ? (quo > W_MIN) : (quo > W_MAX));
  assign wval = wsat ? (qneg ? W_MIN : W_MAX) : (qneg ? -quo : quo);
  assign widx = 2'(di - 3'd1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (!q_status.empty) state_next = S_MUL;
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = (phase && step == LAST_STEP) ? S_DETEND : S_MUL;
      S_DETEND: begin
        if (di == 3'd0) state_next = (acc == '0) ? S_DONE : S_MUL;
        else            state_next = over ? S_WEIGHT : S_DIV;
      end
      S_DIV:    if (cnt == LAST_BIT) state_next = S_WEIGHT;
      S_WEIGHT: state_next = (di == LAST_DET) ? S_DONE : S_MUL;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop        = (state == S_IDLE) && !q_status.empty;
    done       = (state == S_DONE);
    weight_0   = w[0];
    weight_1   = w[1];
    weight_2   = w[2];
    weight_3   = w[3];
    degenerate = deg;
    saturated  = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        work  <= head;
        di    <= 3'd0;
        step  <= 3'd0;
        phase <= 1'b0;
        cx    <= '0;
        cy    <= '0;
        cz    <= '0;
        acc   <= '0;
        deg   <= 1'b0;
        sat   <= 1'b0;
      end
      S_MUL: preg <= opa * opb;
      S_ACC: begin
        if (!phase) begin
          unique case (step[2:1])
            2'd0:    cx <= step[0] ? cx - XW'(preg) : cx + XW'(preg);
            2'd1:    cy <= step[0] ? cy - XW'(preg) : cy + XW'(preg);
            default: cz <= step[0] ? cz - XW'(preg) : cz + XW'(preg);
          endcase
        end else begin
          acc <= step[0] ? acc + (DETW'(preg) <<< (DW + 1)) : acc + DETW'(preg);
        end
        if (step == LAST_STEP) begin
          step  <= 3'd0;
          phase <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
      S_DETEND: begin
        phase <= 1'b0;
        cx    <= '0;
        cy    <= '0;
        cz    <= '0;
        acc   <= '0;
        if (di == 3'd0) begin
          if (acc == '0) begin
            deg <= 1'b1;
            for (int i = 0; i < NUM_CORNERS; i++) w[i] <= '0;
          end else begin
            dmag <= mag;
            dneg <= acc[DETW-1];
            di   <= 3'd1;
          end
        end else begin
          qneg <= acc[DETW-1] ^ dneg;
          ovf  <= over;
          rem  <= nhi;
          low  <= nx[WEIGHT_W-1:0];
          quo  <= '0;
          cnt  <= '0;
        end
      end
      S_DIV: begin
        rem <= ge ? DETW'(trial - {1'b0, dmag}) : trial[DETW-1:0];
        low <= {low[WEIGHT_W-2:0], 1'b0};
        quo <= {quo[WEIGHT_W-2:0], ge};
        cnt <= cnt + 5'd1;
      end
      S_WEIGHT: begin
        w[widx] <= wval;
        if (wsat) sat <= 1'b1;
        di <= di + 3'd1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tetra_barycentric_weights.sv =====
// tetra_barycentric_weights: barycentric weights of a point in a tetrahedron.
// Top level; depends on tbw_pkg, tbw_front, tbw_queue, tbw_back.
`default_nettype none

// A word is accepted when start is high and busy is low. Vertex words
// (is_query = 0) overwrite the corner in vertex_slot at once and give no
// result. Query words take a snapshot of the four corners plus the point into
// a two-entry queue; busy is high only while that queue is full. The back end
// works one query at a time: five 4x4 determinants, each twelve products on
// a single shared multiplier (a multiply state, then an accumulate state);
// after the first, each determinant is followed by a 32-step restoring
// divider for its weight (skipped when the quotient would overflow). A
// degenerate query (zero determinant) ends after the first determinant.
// The result is on weight_0..3, degenerate and saturated for exactly one
// cycle while done is high; the receiver cannot stall it, and those outputs
// are valid only while done is high. Weights carry WEIGHT_FRAC_BITS
// fraction bits, truncate toward zero, and clip to 32 signed bits.

module tetra_barycentric_weights import tbw_pkg::*; #(
  parameter int COORD_WIDTH      = 24,
  parameter int WEIGHT_FRAC_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [COORD_WIDTH-1:0] coord_x,
  input  wire logic [COORD_WIDTH-1:0] coord_y,
  input  wire logic [COORD_WIDTH-1:0] coord_z,
  input  wire logic [1:0]             vertex_slot,
  input  wire logic                   is_query,
  output logic                        done,
  output logic [WEIGHT_W-1:0]         weight_0,
  output logic [WEIGHT_W-1:0]         weight_1,
  output logic [WEIGHT_W-1:0]         weight_2,
  output logic [WEIGHT_W-1:0]         weight_3,
  output logic                        degenerate,
  output logic                        saturated
);

  localparam int ENTRY_W = NUM_ROWS * COORDS * COORD_WIDTH;

  q_status_t          q_status;
  logic               push, pop;
  logic [ENTRY_W-1:0] push_data, head;

  tbw_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .start, .coord_x, .coord_y, .coord_z, .vertex_slot, .is_query,
    .q_status, .busy, .push, .push_data
  );

  tbw_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk, .rst, .push, .push_data, .pop, .status(q_status), .head
  );

  tbw_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_back (
    .clk, .rst, .q_status, .head, .pop, .done,
    .weight_0, .weight_1, .weight_2, .weight_3, .degenerate, .saturated
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tbw_checker.sv =====
// tbw_props: port-level assertions on the result side, bound to the top level.
// Depends on assert_macros.svh and tbw_pkg.
`default_nettype none
`include "assert_macros.svh"

module tbw_props import tbw_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                done,
  input wire logic [WEIGHT_W-1:0] weight_0,
  input wire logic [WEIGHT_W-1:0] weight_1,
  input wire logic [WEIGHT_W-1:0] weight_2,
  input wire logic [WEIGHT_W-1:0] weight_3,
  input wire logic                degenerate,
  input wire logic                saturated
);

  logic any_clip;
  logic all_zero;
  assign any_clip = (weight_0 == W_MAX) || (weight_0 == W_MIN) ||
                    (weight_1 == W_MAX) || (weight_1 == W_MIN) ||
                    (weight_2 == W_MAX) || (weight_2 == W_MIN) ||
                    (weight_3 == W_MAX) || (weight_3 == W_MIN);
  assign all_zero = (weight_0 == '0) && (weight_1 == '0) &&
                    (weight_2 == '0) && (weight_3 == '0);

  // degenerate result: zero weights, no clipping
  `TBW_ASSERT_IMP(a_degen_zero, clk, rst, done && degenerate, all_zero && !saturated)
  // results are never back to back
  `TBW_ASSERT_NXT(a_done_gap, clk, rst, done, !done)
  // a clip flag means some weight sits at a rail
  `TBW_ASSERT_IMP(a_sat_rail, clk, rst, done && saturated, any_clip)

endmodule

bind tetra_barycentric_weights tbw_props u_tbw_props (
  .clk, .rst, .done, .weight_0, .weight_1, .weight_2, .weight_3,
  .degenerate, .saturated
);

`default_nettype wire

// ===== test/tbw_checker.sv =====
// tbw_checker: watches the command and result ports of tetra_barycentric_weights,
// predicts each query's weights from its own copy of the corner store, and counts mismatches.
// Depends on tbw_pkg for the weight width and the saturation limits.
`default_nettype none

module tbw_checker import tbw_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire logic [23:0]   coord_x,
  input  wire logic [23:0]   coord_y,
  input  wire logic [23:0]   coord_z,
  input  wire logic [1:0]    vertex_slot,
  input  wire logic          is_query,
  input  wire logic          done,
  input  wire logic [WEIGHT_W-1:0] weight_0,
  input  wire logic [WEIGHT_W-1:0] weight_1,
  input  wire logic [WEIGHT_W-1:0] weight_2,
  input  wire logic [WEIGHT_W-1:0] weight_3,
  input  wire logic          degenerate,
  input  wire logic          saturated,
  output int                 fail_count,
  output int                 pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [WEIGHT_W-1:0] w [4];
    logic                degen;
    logic                sat;
  } weights_t;

  wide_t    corners [4][3];
  weights_t weights_due [$];

  // determinant of the rows (p, 1), sign fixed by the row order
  function automatic wide_t det_rows(input wide_t r [4][3]);
    wide_t a [3], b [3], c [3];
    for (int k = 0; k < 3; k++) begin
      a[k] = r[1][k] - r[0][k];
      b[k] = r[2][k] - r[0][k];
      c[k] = r[3][k] - r[0][k];
    end
    return a[0]*b[1]*c[2] - a[0]*b[2]*c[1] + a[1]*b[2]*c[0]
         - a[1]*b[0]*c[2] + a[2]*b[0]*c[1] - a[2]*b[1]*c[0];
  endfunction

  function automatic weights_t predict_weights(input wide_t pt [3]);
    weights_t res;
    wide_t    rows [4][3];
    wide_t    den, q;
    den = det_rows(corners);
    res.degen = (den == 0);
    res.sat   = 1'b0;
    for (int i = 0; i < 4; i++) begin
      res.w[i] = '0;
      if (!res.degen) begin
        rows = corners;
        for (int k = 0; k < 3; k++) rows[i][k] = pt[k];
        q = (det_rows(rows) * (wide_t'(1) <<< 24)) / den;   // truncates toward zero
        if (q > wide_t'(32'sh7FFF_FFFF)) begin
          res.w[i] = W_MAX;
          res.sat  = 1'b1;
        end else if (q < -wide_t'(64'sd2147483648)) begin
          res.w[i] = W_MIN;
          res.sat  = 1'b1;
        end else begin
          res.w[i] = q[31:0];
        end
      end
    end
    return res;
  endfunction

  assign pending = weights_due.size();

  always @(posedge clk) begin
    wide_t    pt [3];
    weights_t exp_w, got;
    if (rst) begin
      fail_count <= 0;
      for (int s = 0; s < 4; s++)
        for (int k = 0; k < 3; k++) corners[s][k] = '0;
      weights_due.delete();
    end else begin
      if (done) begin
        got.w[0] = weight_0; got.w[1] = weight_1;
        got.w[2] = weight_2; got.w[3] = weight_3;
        got.degen = degenerate; got.sat = saturated;
        if (weights_due.size() == 0) begin
          $display("%0t: result with no query outstanding", $time);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = weights_due.pop_front();
          if (exp_w.w[0] !== got.w[0] || exp_w.w[1] !== got.w[1] ||
              exp_w.w[2] !== got.w[2] || exp_w.w[3] !== got.w[3] ||
              exp_w.degen !== got.degen || exp_w.sat !== got.sat) begin
            $display("%0t: weights expected %h %h %h %h degen %b sat %b", $time,
                     exp_w.w[0], exp_w.w[1], exp_w.w[2], exp_w.w[3], exp_w.degen, exp_w.sat);
            $display("%0t: weights actual   %h %h %h %h degen %b sat %b", $time,
                     got.w[0], got.w[1], got.w[2], got.w[3], got.degen, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        pt[0] = wide_t'($signed(coord_x));
        pt[1] = wide_t'($signed(coord_y));
        pt[2] = wide_t'($signed(coord_z));
        if (is_query) weights_due.push_back(predict_weights(pt));
        else for (int k = 0; k < 3; k++) corners[vertex_slot][k] = pt[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// tb: stimulus and verdict for tetra_barycentric_weights.
// Depends on tbw_pkg, the block, and tbw_checker (which predicts and compares).
`default_nettype none

module tb import tbw_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, degenerate, saturated;
  logic [23:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [1:0]  vertex_slot = '0;
  logic        is_query = 1'b0;
  logic [WEIGHT_W-1:0] weight_0, weight_1, weight_2, weight_3;
  int fail_count, pending;

  // tb-side copy of what was loaded, used only to aim query points
  logic signed [23:0] loaded [4][3];
  int  words_sent = 0;
  bit  no_gaps = 1'b0;    // stretches of back-to-back words

  always #5 clk = ~clk;

  tetra_barycentric_weights i_dut (.*);
  tbw_checker i_chk (.*);

  // ends a run that hangs; worst legal run is well under a tenth of this
  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // random signed value with the given number of significant bits (1..24)
  function automatic logic signed [23:0] rand_coord(input int bits);
    logic signed [31:0] r;
    r = $signed($urandom) >>> (32 - bits);
    return r[23:0];
  endfunction

  // one word: optional idle gap, then hold start until busy is low at an edge
  task automatic send_word(input logic [23:0] x, y, z, input logic [1:0] slot,
                           input logic q);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    vertex_slot <= slot;
    is_query    <= q;
    do @(posedge clk); while (busy);
    if (!q) begin
      loaded[slot][0] = x; loaded[slot][1] = y; loaded[slot][2] = z;
    end
    words_sent++;
  endtask

  task automatic load_corner(input int s, input int x, y, z);
    send_word(x[23:0], y[23:0], z[23:0], s[1:0], 1'b0);
  endtask

  task automatic query_at(input int x, y, z);
    send_word(x[23:0], y[23:0], z[23:0], 2'd0, 1'b1);
  endtask

  // sender holds off until the back end has drained every query
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int bits, nq, pick;
    logic signed [23:0] px, py, pz;
    for (int s = 0; s < 4; s++)
      for (int k = 0; k < 3; k++) loaded[s][k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all corners at origin after reset -> degenerate
    query_at(4096, 4096, 4096);
    // unit tetrahedron (1.0 = 4096)
    load_corner(0, 0, 0, 0);
    load_corner(1, 4096, 0, 0);
    load_corner(2, 0, 4096, 0);
    load_corner(3, 0, 0, 4096);
    query_at(0, 0, 0);                    // on corner 0
    query_at(1024, 1024, 1024);           // centroid
    query_at(1365, 1365, 1365);           // weights truncate
    query_at(-4096, 8192, 0);             // outside, negative weight
    query_at(8388607, 8388607, 8388607);  // far point, positive clip
    query_at(-8388608, -8388608, -8388608); // far point, negative clip
    drain();
    // tiny tetrahedron at the coordinate extremes
    load_corner(0, -8388608, -8388608, -8388608);
    load_corner(1, -8388607, -8388608, -8388608);
    load_corner(2, -8388608, -8388607, -8388608);
    load_corner(3, -8388608, -8388608, -8388607);
    query_at(8388607, 8388607, 8388607);
    query_at(-8388608, -8388608, -8388608);
    // coplanar corners -> degenerate
    load_corner(3, 4096, 4096, -8388608);
    query_at(0, 0, 0);
    // huge tetrahedron spanning the whole range
    load_corner(0, 8388607, 0, 0);
    load_corner(1, -8388608, 8388607, 0);
    load_corner(2, 0, -8388608, 8388607);
    load_corner(3, 0, 0, -8388608);
    query_at(0, 0, 0);
    drain();

    // random: mostly full tetrahedra at random scales followed by queries
    while (words_sent < 1900) begin
      if ($urandom_range(0, 5) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 40) == 0) drain();
      pick = $urandom_range(0, 9);
      bits = $urandom_range(0, 3) == 0 ? 24 : $urandom_range(2, 23);
      if (pick == 0) begin
        // noise: any word at all
        send_word(rand_coord(24), rand_coord(24), rand_coord(24),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        if (pick == 1) begin
          // move one corner only
          load_corner($urandom_range(0, 3), rand_coord(bits), rand_coord(bits),
                      rand_coord(bits));
        end else begin
          for (int s = 0; s < 4; s++)
            load_corner(s, rand_coord(bits), rand_coord(bits), rand_coord(bits));
        end
        nq = $urandom_range(1, 6);
        for (int n = 0; n < nq; n++) begin
          case ($urandom_range(0, 3))
            0: begin
              // centroid of the loaded corners
              px = 24'((32'(loaded[0][0]) + loaded[1][0] + loaded[2][0] + loaded[3][0]) / 4);
              py = 24'((32'(loaded[0][1]) + loaded[1][1] + loaded[2][1] + loaded[3][1]) / 4);
              pz = 24'((32'(loaded[0][2]) + loaded[1][2] + loaded[2][2] + loaded[3][2]) / 4);
            end
            1: begin
              // near one corner
              pick = $urandom_range(0, 3);
              px = loaded[pick][0] + rand_coord(bits > 3 ? bits - 2 : 1);
              py = loaded[pick][1] + rand_coord(bits > 3 ? bits - 2 : 1);
              pz = loaded[pick][2] + rand_coord(bits > 3 ? bits - 2 : 1);
            end
            2: begin
              px = rand_coord(bits); py = rand_coord(bits); pz = rand_coord(bits);
            end
            default: begin
              px = rand_coord(24); py = rand_coord(24); pz = rand_coord(24);
            end
          endcase
          query_at(px, py, pz);
        end
      end
    end
    start <= 1'b0;

    // let the back end finish, then keep the clock running before the verdict
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
